// ===== hdl/lsxu_pkg.sv =====
// Shared types and constants for the LEGv8-subset execute unit.
// Used by every module under hdl/; depends on nothing else.
package lsxu_pkg;

  localparam int REG_COUNT_DEF = 32;
  localparam int MEM_WORDS_DEF = 4096;

  localparam logic [15:0] START_PC_RESET = 16'd200;

  // Depths of the instruction queue and the result queue (powers of two).
  localparam int FQ_DEPTH = 4;
  localparam int OQ_DEPTH = 8;
  localparam int OQ_CW    = $clog2(OQ_DEPTH) + 1;

  // Configuration register indexes (address bit 2 of the APB port).
  localparam logic REG_START_PC = 1'b0;

  typedef enum logic [2:0] {
    OP_ADD  = 3'd0,
    OP_ADDI = 3'd1,
    OP_LDUR = 3'd2,
    OP_STUR = 3'd3,
    OP_B    = 3'd4,
    OP_AND  = 3'd5,
    OP_BEQ  = 3'd6,
    OP_NOP  = 3'd7
  } op_t;

  // Decoded instruction as it travels from the front end to the back end.
  typedef struct packed {
    logic        use_imm;
    logic        is_and;
    logic        is_load;
    logic        is_store;
    logic        is_branch;
    logic        is_beq;
    logic        writes_reg;
    logic [4:0]  src0;
    logic [4:0]  src1;
    logic [4:0]  dest;
    logic [31:0] imm;
    logic [15:0] target;
  } uop_t;

  typedef struct packed {
    logic [15:0] pc_value;
    logic        reg_written;
    logic [4:0]  written_reg_index;
    logic [31:0] written_value;
    logic        mem_written;
    logic [11:0] mem_index;
    logic [31:0] store_value;
    logic        address_fault;
  } result_t;

endpackage

// ===== hdl/lsxu_front.sv =====
// Front end: decodes incoming instructions into operand selects and flags
// and holds them in a small queue for the back end. Depends on lsxu_pkg.
module lsxu_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  input  logic               hold,
  output logic               full,
  input  logic [2:0]         operation,
  input  logic [4:0]         first_reg,
  input  logic [4:0]         second_reg,
  input  logic [4:0]         third_reg,
  input  logic [31:0]        immediate,
  input  logic [15:0]        instr_address,
  output logic               q_valid,
  output lsxu_pkg::uop_t     q_uop,
  input  logic               deq
);
  import lsxu_pkg::*;

  localparam int FQ_AW = $clog2(FQ_DEPTH);
  localparam logic [FQ_AW:0] FQ_CNT_FULL = FQ_DEPTH[FQ_AW:0];

  uop_t             dec;
  uop_t             fq_r [FQ_DEPTH];
  logic [FQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [FQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [FQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  always_comb begin
    dec            = '0;
    dec.imm        = immediate;
    dec.target     = instr_address;
    dec.dest       = first_reg;
    dec.src0       = second_reg;
    dec.src1       = third_reg;
    case (operation)
      OP_ADD: begin
        dec.writes_reg = 1'b1;
      end
      OP_ADDI: begin
        dec.writes_reg = 1'b1;
        dec.use_imm    = 1'b1;
      end
      OP_AND: begin
        dec.writes_reg = 1'b1;
        dec.is_and     = 1'b1;
      end
      OP_LDUR: begin
        dec.writes_reg = 1'b1;
        dec.use_imm    = 1'b1;
        dec.is_load    = 1'b1;
      end
      OP_STUR: begin
        dec.use_imm  = 1'b1;
        dec.is_store = 1'b1;
        dec.src1     = first_reg;
      end
      OP_B: begin
        dec.is_branch = 1'b1;
      end
      OP_BEQ: begin
        dec.is_beq = 1'b1;
        dec.src0   = first_reg;
        dec.src1   = second_reg;
      end
      default: begin
      end
    endcase
  end

  assign full    = (cnt_r == FQ_CNT_FULL) | hold;
  assign do_push = push & ~full;
  assign q_valid = (cnt_r != '0);
  assign do_pop  = deq & q_valid;
  assign q_uop   = fq_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = do_push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      fq_r[wr_ptr_r] <= dec;
    end
  end

endmodule

// ===== hdl/lsxu_back.sv =====
// Back end: register file, data memory, ALU, branch unit and program counter,
// in a two-stage execute/writeback pipe with forwarding. Depends on lsxu_pkg.
module lsxu_back #(
  parameter int REG_COUNT = lsxu_pkg::REG_COUNT_DEF,
  parameter int MEM_WORDS = lsxu_pkg::MEM_WORDS_DEF
) (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     q_valid,
  input  lsxu_pkg::uop_t           q_uop,
  output logic                     deq,
  input  logic [lsxu_pkg::OQ_CW-1:0] out_cnt,
  output logic                     clearing,
  output logic                     res_push,
  output lsxu_pkg::result_t        res
);
  import lsxu_pkg::*;

  localparam int RIDX_W = (REG_COUNT > 1) ? $clog2(REG_COUNT) : 1;
  localparam int MIDX_W = $clog2(MEM_WORDS);
  localparam int OCC_W  = OQ_CW + 1;
  localparam logic [31:0]       REG_LIM = 32'(REG_COUNT);
  localparam logic [31:0]       MEM_LIM = 32'(MEM_WORDS);
  localparam logic [MIDX_W-1:0] MEM_LAST = MIDX_W'(MEM_WORDS - 1);

  logic [31:0]          rf [REG_COUNT];
  logic [REG_COUNT-1:0] rf_vld_r;
  logic [31:0]          dmem [MEM_WORDS];

  logic              clr_busy_r, clr_busy_nxt;
  logic [MIDX_W-1:0] clr_cnt_r, clr_cnt_nxt;

  logic [OCC_W-1:0]  occ;
  logic              ok0_nxt, ok1_nxt;

  logic              e2_vld_r;
  uop_t              e2_uop_r;
  logic              e2_ok0_r, e2_ok1_r;
  logic [31:0]       rd0_r, rd1_r;

  logic              e3_vld_r;
  logic              e3_load_r;
  result_t           e3_res_r, e3_res_nxt;
  logic [31:0]       e3_wval;
  logic              e3_wr;

  logic              w_vld_r;
  logic [4:0]        w_idx_r;
  logic [31:0]       w_val_r;

  logic [31:0]       s0, s1, opnd, sum, alu;
  logic              fault, wflag, mflag, taken, mem_op, dest_ok;
  logic [15:0]       pc_r, pc_nxt;

  logic              mem_we, mem_re;
  logic [MIDX_W-1:0] mem_addr;
  logic [31:0]       mem_wdata, mem_rdata_r;

  // Data memory clearing pass after reset, one word per cycle.
  always_comb begin
    clr_busy_nxt = clr_busy_r;
    clr_cnt_nxt  = clr_cnt_r;
    if (clr_busy_r) begin
      clr_cnt_nxt = clr_cnt_r + 1'b1;
      if (clr_cnt_r == MEM_LAST) begin
        clr_busy_nxt = 1'b0;
      end
    end
  end

  assign clearing = clr_busy_r;

  // Issue only when the result queue is sure to have room for everything
  // in flight, so the execute pipe never has to stall.
  assign occ = OCC_W'(out_cnt) + OCC_W'(e2_vld_r) + OCC_W'(e3_vld_r);
  assign deq = q_valid & ~clr_busy_r & (occ < OCC_W'(OQ_DEPTH));

  assign ok0_nxt = (32'(q_uop.src0) < REG_LIM) && rf_vld_r[RIDX_W'(q_uop.src0)];
  assign ok1_nxt = (32'(q_uop.src1) < REG_LIM) && rf_vld_r[RIDX_W'(q_uop.src1)];

  // Writeback value: a load takes the memory read data.
  assign e3_wval = e3_load_r ? mem_rdata_r : e3_res_r.written_value;
  assign e3_wr   = e3_vld_r & e3_res_r.reg_written;

  // Operand forwarding: the writeback stage first, then the write made at
  // the previous edge, which the register file read could not yet see.
  always_comb begin
    if (e3_wr && e3_res_r.written_reg_index == e2_uop_r.src0) begin
      s0 = e3_wval;
    end else if (w_vld_r && w_idx_r == e2_uop_r.src0) begin
      s0 = w_val_r;
    end else if (e2_ok0_r) begin
      s0 = rd0_r;
    end else begin
      s0 = '0;
    end
    if (e3_wr && e3_res_r.written_reg_index == e2_uop_r.src1) begin
      s1 = e3_wval;
    end else if (w_vld_r && w_idx_r == e2_uop_r.src1) begin
      s1 = w_val_r;
    end else if (e2_ok1_r) begin
      s1 = rd1_r;
    end else begin
      s1 = '0;
    end
  end

  always_comb begin
    opnd    = e2_uop_r.use_imm ? e2_uop_r.imm : s1;
    sum     = s0 + opnd;
    alu     = e2_uop_r.is_and ? (s0 & s1) : sum;
    mem_op  = e2_uop_r.is_load | e2_uop_r.is_store;
    fault   = mem_op & (sum[31] | (sum >= MEM_LIM));
    dest_ok = 32'(e2_uop_r.dest) < REG_LIM;
    wflag   = e2_vld_r & e2_uop_r.writes_reg & dest_ok & ~fault;
    mflag   = e2_vld_r & e2_uop_r.is_store & ~fault;
    taken   = e2_uop_r.is_branch | (e2_uop_r.is_beq & (s0 == s1));
    pc_nxt  = (e2_vld_r && taken) ? e2_uop_r.target : pc_r;

    e3_res_nxt                   = '0;
    e3_res_nxt.pc_value          = pc_nxt;
    e3_res_nxt.reg_written       = wflag;
    e3_res_nxt.written_reg_index = wflag ? e2_uop_r.dest : 5'd0;
    e3_res_nxt.written_value     = (wflag && !e2_uop_r.is_load) ? alu : 32'd0;
    e3_res_nxt.mem_written       = mflag;
    e3_res_nxt.mem_index         = mem_op ? sum[11:0] : 12'd0;
    e3_res_nxt.store_value       = mflag ? s1 : 32'd0;
    e3_res_nxt.address_fault     = fault;

    mem_re    = e2_vld_r & e2_uop_r.is_load & ~fault;
    mem_we    = clr_busy_r | mflag;
    mem_addr  = clr_busy_r ? clr_cnt_r : MIDX_W'(sum);
    mem_wdata = clr_busy_r ? 32'd0 : s1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_busy_r <= 1'b1;
      clr_cnt_r  <= '0;
      rf_vld_r   <= '0;
      e2_vld_r   <= 1'b0;
      e3_vld_r   <= 1'b0;
      w_vld_r    <= 1'b0;
      pc_r       <= START_PC_RESET;
    end else begin
      clr_busy_r <= clr_busy_nxt;
      clr_cnt_r  <= clr_cnt_nxt;
      e2_vld_r   <= deq;
      e3_vld_r   <= e2_vld_r;
      w_vld_r    <= e3_wr;
      pc_r       <= pc_nxt;
      if (e3_wr) begin
        rf_vld_r[RIDX_W'(e3_res_r.written_reg_index)] <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    e2_uop_r  <= q_uop;
    e2_ok0_r  <= ok0_nxt;
    e2_ok1_r  <= ok1_nxt;
    e3_res_r  <= e3_res_nxt;
    e3_load_r <= e2_uop_r.is_load & wflag;
    w_idx_r   <= e3_res_r.written_reg_index;
    w_val_r   <= e3_wval;
  end

  // Register file: one write port, two registered read ports.
  always_ff @(posedge clk) begin
    if (e3_wr) begin
      rf[RIDX_W'(e3_res_r.written_reg_index)] <= e3_wval;
    end
    rd0_r <= rf[RIDX_W'(q_uop.src0)];
    rd1_r <= rf[RIDX_W'(q_uop.src1)];
  end

  // Data memory: single port, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      dmem[mem_addr] <= mem_wdata;
    end
    if (mem_re) begin
      mem_rdata_r <= dmem[mem_addr];
    end
  end

  always_comb begin
    res               = e3_res_r;
    res.written_value = e3_wval;
  end

  assign res_push = e3_vld_r;

endmodule

// ===== hdl/lsxu_outq.sv =====
// Result queue between the execute pipe and the result ports.
// Depends on lsxu_pkg for the result type and depth.
module lsxu_outq (
  input  logic                       clk,
  input  logic                       rst_n,
  input  logic                       push,
  input  lsxu_pkg::result_t          din,
  input  logic                       pop,
  output logic                       empty,
  output lsxu_pkg::result_t          dout,
  output logic [lsxu_pkg::OQ_CW-1:0] cnt
);
  import lsxu_pkg::*;

  localparam int OQ_AW = $clog2(OQ_DEPTH);

  result_t          oq_r [OQ_DEPTH];
  logic [OQ_AW-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [OQ_AW-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [OQ_AW:0]   cnt_r, cnt_nxt;
  logic             do_pop;

  assign empty  = (cnt_r == '0);
  assign do_pop = pop & ~empty;
  assign dout   = oq_r[rd_ptr_r];
  assign cnt    = cnt_r;

  always_comb begin
    wr_ptr_nxt = push ? wr_ptr_r + 1'b1 : wr_ptr_r;
    rd_ptr_nxt = do_pop ? rd_ptr_r + 1'b1 : rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      oq_r[wr_ptr_r] <= din;
    end
  end

endmodule

// ===== hdl/legv8_subset_execute_unit.sv =====
// Top level of the LEGv8-subset execute unit: APB register, front end,
// back end and result queue. Depends on lsxu_pkg and the lsxu_* modules.
//
// Executes ADD, ADDI, AND, LDUR, STUR, B and BEQ against a register file, a
// data memory and a program counter, one result per instruction, in order.
// Sustained rate is one instruction per cycle while the result side keeps up
// and no clearing pass runs. When nothing waits ahead of it, an instruction's
// result reaches the result ports through the front queue, the operand read
// registers, execute, the writeback registers and the result queue, with
// back-to-back dependences resolved by forwarding. After reset all MEM_WORDS
// words of data memory (4096 by default) are cleared one word per cycle; full
// stays high during that pass, while the APB register can still be written.
// start_pc is stored and readable; the program counter itself resets to 200.
module legv8_subset_execute_unit #(
  parameter int REG_COUNT = lsxu_pkg::REG_COUNT_DEF,
  parameter int MEM_WORDS = lsxu_pkg::MEM_WORDS_DEF
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               push,
  output logic               full,
  input  logic [2:0]         in_operation,
  input  logic [4:0]         in_first_reg,
  input  logic [4:0]         in_second_reg,
  input  logic [4:0]         in_third_reg,
  input  logic signed [31:0] in_immediate,
  input  logic [15:0]        in_instr_address,
  output logic               empty,
  input  logic               pop,
  output logic [15:0]        out_pc_value,
  output logic               out_reg_written,
  output logic [4:0]         out_written_reg_index,
  output logic signed [31:0] out_written_value,
  output logic               out_mem_written,
  output logic [11:0]        out_mem_index,
  output logic signed [31:0] out_store_value,
  output logic               out_address_fault,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [2:0]         paddr,
  input  logic [31:0]        pwdata,
  output logic [31:0]        prdata,
  output logic               pready
);
  import lsxu_pkg::*;

  logic              q_valid, deq, clearing, res_push;
  uop_t              q_uop;
  result_t           res, head;
  logic [OQ_CW-1:0]  out_cnt;
  logic [15:0]       start_pc_r;
  logic              cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & pready;
  assign prdata = (paddr[2] == REG_START_PC) ? {16'd0, start_pc_r} : 32'd0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      start_pc_r <= START_PC_RESET;
    end else if (cfg_wr && paddr[2] == REG_START_PC) begin
      start_pc_r <= pwdata[15:0];
    end
  end

  lsxu_front u_front (
    .clk           (clk),
    .rst_n         (rst_n),
    .push          (push),
    .hold          (clearing),
    .full          (full),
    .operation     (in_operation),
    .first_reg     (in_first_reg),
    .second_reg    (in_second_reg),
    .third_reg     (in_third_reg),
    .immediate     (in_immediate),
    .instr_address (in_instr_address),
    .q_valid       (q_valid),
    .q_uop         (q_uop),
    .deq           (deq)
  );

  lsxu_back #(
    .REG_COUNT (REG_COUNT),
    .MEM_WORDS (MEM_WORDS)
  ) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .q_valid  (q_valid),
    .q_uop    (q_uop),
    .deq      (deq),
    .out_cnt  (out_cnt),
    .clearing (clearing),
    .res_push (res_push),
    .res      (res)
  );

  lsxu_outq u_outq (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (res_push),
    .din   (res),
    .pop   (pop),
    .empty (empty),
    .dout  (head),
    .cnt   (out_cnt)
  );

  assign out_pc_value          = head.pc_value;
  assign out_reg_written       = head.reg_written;
  assign out_written_reg_index = head.written_reg_index;
  assign out_written_value     = head.written_value;
  assign out_mem_written       = head.mem_written;
  assign out_mem_index         = head.mem_index;
  assign out_store_value       = head.store_value;
  assign out_address_fault     = head.address_fault;

endmodule
